// ----- rtl/core/rect_polar_converter_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rectangular/polar converter core
// Short forms of the concurrent checks used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef RECT_POLAR_CONVERTER_CORE_MACROS_SVH
`define RECT_POLAR_CONVERTER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define RPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpc: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpc: next-cycle check failed");

`endif

// ----- rtl/core/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and the arctangent table of the rectangular/polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int DATA_W   = 16;               // field width
  localparam int FRAC_W   = 24;               // fraction bits of CORDIC coordinates
  localparam int ANG_W    = 32;               // internal angle, full turn = 2^ANG_W
  localparam int ANG_SH   = ANG_W - DATA_W;   // internal to field angle shift
  localparam int CW       = DATA_W + FRAC_W + 3;
  localparam int SQ_W     = 2 * DATA_W;       // sum of squares
  localparam int SQ_STEPS = DATA_W;           // root bits
  localparam int GAIN_FRAC = 32;
  localparam int GAIN_SH  = GAIN_FRAC - FRAC_W;
  localparam int PROD_W   = DATA_W + 1 + GAIN_FRAC;
  localparam int SC_W     = PROD_W - GAIN_SH;
  localparam int RND_W    = CW - FRAC_W;

  localparam logic [GAIN_FRAC-1:0]    GAIN_INV     = 32'h9B74_EDA8;
  localparam logic [ANG_W-1:0]        HALF_TURN    = 32'h8000_0000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 32'sh4000_0000;

  typedef enum logic [1:0] {
    MODE_RECT  = 2'd0,
    MODE_POLAR = 2'd1
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VEC = 2'd0,   // vectoring: rectangular in
    KIND_ROT = 2'd1,   // rotation: polar in
    KIND_BAD = 2'd2    // invalid mode
  } kind_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] second_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_out;
    logic signed [DATA_W-1:0] y_out;
    logic [DATA_W-1:0]        magnitude;
    logic signed [DATA_W-1:0] angle;
    logic                     bad_mode;
  } out_t;

  typedef struct packed {
    kind_t                kind;
    logic                 zero;     // zero vector
    logic [DATA_W-1:0]    pass_a;   // x, or polar magnitude echo
    logic [DATA_W-1:0]    pass_b;   // y, or polar angle echo
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_W-1:0]     z;
    logic [SQ_W-1:0]      rem;      // square root remainder
    logic [SQ_W-1:0]      root;     // square root partial result
  } stage_t;

  // atan(2^-i) in turns, 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turns(input int unsigned idx);
    case (idx)
      0:  atan_turns = 32'h2000_0000;
      1:  atan_turns = 32'h12E4_051E;
      2:  atan_turns = 32'h09FB_385B;
      3:  atan_turns = 32'h0511_11D4;
      4:  atan_turns = 32'h028B_0D43;
      5:  atan_turns = 32'h0145_D7E1;
      6:  atan_turns = 32'h00A2_F61E;
      7:  atan_turns = 32'h0051_7C55;
      8:  atan_turns = 32'h0028_BE53;
      9:  atan_turns = 32'h0014_5F2F;
      10: atan_turns = 32'h000A_2F98;
      11: atan_turns = 32'h0005_17CC;
      12: atan_turns = 32'h0002_8BE6;
      13: atan_turns = 32'h0001_45F3;
      14: atan_turns = 32'h0000_A2FA;
      15: atan_turns = 32'h0000_517D;
      16: atan_turns = 32'h0000_28BE;
      17: atan_turns = 32'h0000_145F;
      18: atan_turns = 32'h0000_0A30;
      19: atan_turns = 32'h0000_0518;
      20: atan_turns = 32'h0000_028C;
      21: atan_turns = 32'h0000_0146;
      22: atan_turns = 32'h0000_00A3;
      23: atan_turns = 32'h0000_0051;
      24: atan_turns = 32'h0000_0029;
      25: atan_turns = 32'h0000_0014;
      26: atan_turns = 32'h0000_000A;
      27: atan_turns = 32'h0000_0005;
      28: atan_turns = 32'h0000_0003;
      29: atan_turns = 32'h0000_0001;
      30: atan_turns = 32'h0000_0001;
      default: atan_turns = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rpc_prep.sv -----
// ----------------------------------------------------------------------------
// rpc_prep
// Three-stage front end: capture, multiply, form the CORDIC start vector.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_prep import rpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_vld,
  input  in_t    in_word,
  output logic   out_vld,
  output stage_t out_word
);

  // capture stage
  logic vld1;
  in_t  word1;

  // multiply stage
  logic                     vld2;
  kind_t                    kind2;
  logic signed [DATA_W-1:0] a2;
  logic signed [DATA_W-1:0] b2;
  logic [SQ_W-1:0]          sqa2;
  logic [SQ_W-1:0]          sqb2;
  logic [PROD_W-1:0]        prod2;
  logic [ANG_W-1:0]         zp2;
  logic [DATA_W-1:0]        mag2;

  kind_t                    kind_next;
  logic signed [DATA_W:0]   a_ext;
  logic [DATA_W:0]          mag_abs;
  logic [ANG_W-1:0]         zp_next;
  logic signed [SQ_W-1:0]   sqa_next;
  logic signed [SQ_W-1:0]   sqb_next;
  logic [PROD_W-1:0]        prod_next;

  // start vector stage
  localparam logic [PROD_W-1:0] GAIN_RND = PROD_W'(1) << (GAIN_SH - 1);

  logic [SQ_W-1:0]      n_sum;
  logic signed [CW-1:0] a_cw;
  logic signed [CW-1:0] b_cw;
  logic signed [CW-1:0] xa;
  logic signed [CW-1:0] yb;
  logic [PROD_W-1:0]    rnd;
  logic signed [CW-1:0] sc;
  logic                 pre;
  stage_t               word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    word1    <= in_word;
    kind2    <= kind_next;
    a2       <= word1.first_value;
    b2       <= word1.second_value;
    sqa2     <= sqa_next;
    sqb2     <= sqb_next;
    prod2    <= prod_next;
    zp2      <= zp_next;
    mag2     <= mag_abs[DATA_W-1:0];
    out_word <= word_next;
  end

  always_comb begin
    case (word1.mode)
      MODE_RECT:  kind_next = KIND_VEC;
      MODE_POLAR: kind_next = KIND_ROT;
      default:    kind_next = KIND_BAD;
    endcase
    a_ext   = {word1.first_value[DATA_W-1], word1.first_value};
    mag_abs = a_ext[DATA_W] ? -a_ext : a_ext;
    // a negative magnitude turns the angle by half a turn
    zp_next = {word1.second_value, {ANG_SH{1'b0}}};
    if (a_ext[DATA_W]) begin
      zp_next = zp_next + HALF_TURN;
    end
    sqa_next  = SQ_W'(word1.first_value) * SQ_W'(word1.first_value);
    sqb_next  = SQ_W'(word1.second_value) * SQ_W'(word1.second_value);
    prod_next = PROD_W'(mag_abs) * PROD_W'(GAIN_INV);
  end

  always_comb begin
    n_sum = sqa2 + sqb2;
    a_cw  = {{(CW-DATA_W){a2[DATA_W-1]}}, a2};
    b_cw  = {{(CW-DATA_W){b2[DATA_W-1]}}, b2};
    xa    = a_cw <<< FRAC_W;
    yb    = b_cw <<< FRAC_W;
    rnd   = prod2 + GAIN_RND;
    sc    = {{(CW-SC_W){1'b0}}, rnd[PROD_W-1:GAIN_SH]};
    pre   = ($signed(zp2) > QUARTER_TURN) || ($signed(zp2) < -QUARTER_TURN);

    word_next.kind = kind2;
    word_next.rem  = n_sum;
    word_next.root = '0;
    case (kind2)
      KIND_ROT: begin
        // fold angles beyond a quarter turn onto the right half plane
        word_next.zero   = 1'b0;
        word_next.pass_a = mag2;
        word_next.pass_b = zp2[ANG_W-1:ANG_SH];
        word_next.x      = pre ? -sc : sc;
        word_next.y      = '0;
        word_next.z      = pre ? zp2 + HALF_TURN : zp2;
      end
      default: begin
        // left half plane: turn by half a turn first
        word_next.zero   = (a2 == '0) && (b2 == '0);
        word_next.pass_a = a2;
        word_next.pass_b = b2;
        word_next.x      = a2[DATA_W-1] ? -xa : xa;
        word_next.y      = a2[DATA_W-1] ? -yb : yb;
        word_next.z      = a2[DATA_W-1] ? HALF_TURN : '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/rpc_stage.sv -----
// ----------------------------------------------------------------------------
// rpc_stage
// Pipeline step: a CORDIC micro-rotation if DO_ROT, a root digit if DO_SQRT.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_stage import rpc_pkg::*; #(
  parameter int IDX        = 0,
  parameter int ITERATIONS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_vld,
  input  stage_t in_word,
  output logic   out_vld,
  output stage_t out_word
);

  localparam bit DO_ROT  = IDX < ITERATIONS;
  localparam bit DO_SQRT = IDX < SQ_STEPS;
  localparam int SQ_POS  = DO_SQRT ? (SQ_W - 2 - 2 * IDX) : 0;
  localparam logic [ANG_W-1:0] ATAN   = atan_turns(IDX);
  localparam logic [SQ_W:0]    SQ_BIT = (SQ_W + 1)'(1) << SQ_POS;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic                 ccw;
  logic [SQ_W:0]        trial;
  stage_t               word_next;

  always_comb begin
    word_next = in_word;
    xs        = in_word.x;
    ys        = in_word.y;
    dx        = ys >>> IDX;
    dy        = xs >>> IDX;
    // vectoring drives y to zero, rotation drives z to zero
    ccw       = (in_word.kind == KIND_VEC) ? ys[CW-1] : ~in_word.z[ANG_W-1];
    trial     = {1'b0, in_word.root} + SQ_BIT;
    if (DO_ROT) begin
      if (ccw) begin
        word_next.x = xs - dx;
        word_next.y = ys + dy;
        word_next.z = in_word.z - ATAN;
      end else begin
        word_next.x = xs + dx;
        word_next.y = ys - dy;
        word_next.z = in_word.z + ATAN;
      end
    end
    if (DO_SQRT) begin
      if ({1'b0, in_word.rem} >= trial) begin
        word_next.rem  = in_word.rem - trial[SQ_W-1:0];
        word_next.root = (in_word.root >> 1) + SQ_BIT[SQ_W-1:0];
      end else begin
        word_next.root = in_word.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/rpc_finish.sv -----
// ----------------------------------------------------------------------------
// rpc_finish
// Output stage: round, saturate and select the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_finish import rpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_vld,
  input  stage_t in_word,
  output logic   done,
  output out_t   result
);

  localparam logic signed [CW-1:0] HALF_LSB   = CW'(1) <<< (FRAC_W - 1);
  localparam logic [ANG_W-1:0]     ANG_HALF   = ANG_W'(1) << (ANG_SH - 1);

  logic signed [CW-1:0] xsum;
  logic signed [CW-1:0] ysum;
  logic [ANG_W-1:0]     zsum;
  logic [SQ_W-1:0]      mag_rnd;
  out_t                 result_next;

  function automatic logic [DATA_W-1:0] sat(input logic [RND_W-1:0] v);
    logic [RND_W-DATA_W:0] top;
    top = v[RND_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      sat = v[DATA_W-1:0];
    end else if (v[RND_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    xsum    = in_word.x + HALF_LSB;
    ysum    = in_word.y + HALF_LSB;
    zsum    = in_word.z + ANG_HALF;
    // round the root up when the remainder exceeds it
    mag_rnd = (in_word.rem > in_word.root) ? in_word.root + 1'b1 : in_word.root;
    case (in_word.kind)
      KIND_VEC: begin
        result_next.x_out     = in_word.pass_a;
        result_next.y_out     = in_word.pass_b;
        result_next.magnitude = mag_rnd[DATA_W-1:0];
        result_next.angle     = in_word.zero ? '0 : zsum[ANG_W-1:ANG_SH];
        result_next.bad_mode  = 1'b0;
      end
      KIND_ROT: begin
        result_next.x_out     = sat(xsum[CW-1:FRAC_W]);
        result_next.y_out     = sat(ysum[CW-1:FRAC_W]);
        result_next.magnitude = in_word.pass_a;
        result_next.angle     = in_word.pass_b;
        result_next.bad_mode  = 1'b0;
      end
      default: begin
        result_next          = '0;
        result_next.bad_mode = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/rect_polar_converter_core.sv -----
// The done strobe follows an accepted command word through the prep capture,
//   multiply and start vector registers, the stage chain and rpc_finish.
// Throughput: one word per cycle while busy is low; depth is set by the CORDIC
//   stages and the 16-digit square root chain that runs beside them.
// Reset: synchronous; clears every valid bit, busy is high for one cycle after.
// ----------------------------------------------------------------------------
// rect_polar_converter_core
// Rectangular to polar (magnitude, atan2) and polar to rectangular conversion
// in one fully pipelined CORDIC, angles in binary units.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rect_polar_converter_core_macros.svh"

module rect_polar_converter_core import rpc_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  cmd,
  output logic busy,
  output logic done,
  output out_t result
);

  // the square root needs a stage per root bit, the CORDIC one per iteration;
  // both share one chain, so the longer of the two sets its length
  localparam int NSTAGE = (ITERATIONS > SQ_STEPS) ? ITERATIONS : SQ_STEPS;

  logic           accept;
  logic [NSTAGE:0] stg_vld;
  stage_t         stg_word [NSTAGE+1];
  logic           fields_zero;

  // busy only covers the cycle after reset; the pipe never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // capture, square / scale, start vector
  rpc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .in_word  (cmd),
    .out_vld  (stg_vld[0]),
    .out_word (stg_word[0])
  );

  // per stage: CORDIC iteration (k < ITERATIONS), root digit (k < SQ_STEPS)
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    rpc_stage #(
      .IDX        (k),
      .ITERATIONS (ITERATIONS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (stg_vld[k]),
      .in_word  (stg_word[k]),
      .out_vld  (stg_vld[k+1]),
      .out_word (stg_word[k+1])
    );
  end

  // round, saturate and drive the result word for one cycle
  rpc_finish u_finish (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (stg_vld[NSTAGE]),
    .in_word (stg_word[NSTAGE]),
    .done    (done),
    .result  (result)
  );

  assign fields_zero = (result.x_out == '0) && (result.y_out == '0) &&
                       (result.magnitude == '0) && (result.angle == '0);

  // an invalid mode must leave every numeric field at zero
  `RPC_ASSERT_IMPL(a_bad_zero, clk, rst, done && result.bad_mode, fields_zero)
  // a strobe only follows a valid word at the end of the chain
  `RPC_ASSERT_IMPL(a_done_src, clk, rst, done, $past(stg_vld[NSTAGE]))
  // straight after reset the pipe holds nothing
  `RPC_ASSERT_IMPL(a_busy_empty, clk, rst, busy, !done && stg_vld == '0)
  // busy is low in the cycle after any cycle in which it is high
  `RPC_ASSERT_NEXT(a_busy_short, clk, rst, busy, !busy)

endmodule

`default_nettype wire
